FILE: rtl/core/bpvc_pkg.sv
`timescale 1ns / 1ps

package bpvc_pkg;

  localparam int LENGTH_BITS = 17;
  localparam int MAX_MSTI = 64;
  localparam int FRAME_LEN_W = 17;
  localparam int CLASS_W = 3;
  localparam int BV_W = 3;
  localparam int POS_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic [BV_W-1:0] bv_t;

  localparam len_t LEN_MAX = {LENGTH_BITS{1'b1}};

  localparam int V1_OFFSET = 35;
  localparam int V3_OFFSET = 36;
  localparam int V3_END = 38;
  localparam int SHORT_LIMIT = 102;
  localparam int SPT_LIMIT = 106;
  localparam int SPT_V4_MIN = 55;
  localparam int CIST_V3_LEN = 64;
  localparam int MSTI_MSG_LEN = 16;
  localparam int SPT_TRAILER = 6;
  localparam int V3_MAX = CIST_V3_LEN + MSTI_MSG_LEN * MAX_MSTI;

  localparam logic [7:0] TYPE_CONFIG = 8'h00;
  localparam logic [7:0] TYPE_RST = 8'h02;
  localparam logic [7:0] TYPE_TCN = 8'h80;

  localparam bv_t BV_RSTP = 3'd2;
  localparam bv_t BV_MSTP = 3'd3;

  localparam class_t CLASS_UNKNOWN = 3'd0;
  localparam class_t CLASS_STP = 3'd1;
  localparam class_t CLASS_TCN = 3'd2;
  localparam class_t CLASS_RST = 3'd3;
  localparam class_t CLASS_MST = 3'd4;
  localparam class_t CLASS_SPT = 3'd5;

  typedef struct packed {
    len_t size;
    logic proto_nonzero;
    logic [7:0] version_id;
    logic [7:0] type_code;
    logic [7:0] v1_length;
    logic [15:0] v3_length;
    logic [15:0] v4_length;
    logic [7:0] selector_byte;
  } frame_t;

endpackage

FILE: rtl/core/bpvc_if.sv
`timescale 1ns / 1ps

interface bpvc_octet_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bpvc_result_if;
  logic valid;
  logic ready;
  logic [bpvc_pkg::CLASS_W-1:0] bpdu_class;
  logic [bpvc_pkg::FRAME_LEN_W-1:0] frame_length;
  modport source (output valid, output bpdu_class, output frame_length, input ready);
  modport sink (input valid, input bpdu_class, input frame_length, output ready);
endinterface

interface bpvc_cfg_if;
  logic valid;
  logic ready;
  logic [bpvc_pkg::BV_W-1:0] bridge_protocol_version;
  modport source (output valid, output bridge_protocol_version, input ready);
  modport sink (input valid, input bridge_protocol_version, output ready);
endinterface

FILE: rtl/core/bpdu_validation_classifier.sv
`timescale 1ns / 1ps

// Spanning-tree BPDU validation and classification. Octets of one BPDU enter
// on the octet channel at up to one per cycle, starting at the protocol
// identifier, with last_byte set on the final octet. Each octet passes an input
// register and is then captured into the header, length and selector fields;
// on the final octet one result (class and saturated octet count) is loaded
// into the result register when that octet leaves the input register. The
// only back-pressure comes from a result still waiting in the result register
// when the next final octet reaches it; otherwise one octet is taken every
// cycle. The bridge protocol version register resets to 3 (MSTP); write it
// only while no BPDU is in flight.
module bpdu_validation_classifier (
  input  logic                   clk,
  input  logic                   rst,
  bpvc_cfg_if.sink               cfg,
  bpvc_octet_if.sink             octet,
  bpvc_result_if.source          result
);

  bpvc_pkg::bv_t bridge_version;

  logic s1_valid;
  logic [7:0] s1_byte;
  logic s1_last;
  logic s1_go;
  logic out_free;

  bpvc_pkg::len_t byte_count;
  logic proto_nonzero;
  logic [7:0] version_id;
  logic [7:0] type_code;
  logic [7:0] v1_length;
  logic [15:0] v3_length;
  logic [15:0] v4_length;
  logic [7:0] selector_byte;

  bpvc_pkg::frame_t frame_next;
  bpvc_pkg::pos_t idx_pos;
  bpvc_pkg::pos_t v4_pos;
  bpvc_pkg::class_t class_next;

  logic out_valid;
  bpvc_pkg::class_t out_class;
  logic [bpvc_pkg::FRAME_LEN_W-1:0] out_length;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bridge_version <= bpvc_pkg::BV_MSTP;
    end else if (cfg.valid) begin
      bridge_version <= cfg.bridge_protocol_version;
    end
  end

  assign out_free = !out_valid || result.ready;
  assign s1_go = s1_valid && (!s1_last || out_free);
  assign octet.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (octet.valid && octet.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (octet.valid && octet.ready) begin
      s1_byte <= octet.data_byte;
      s1_last <= octet.last_byte;
    end
  end

  // field capture for the octet in the input register
  always_comb begin
    frame_next.size = byte_count;
    frame_next.proto_nonzero = proto_nonzero;
    frame_next.version_id = version_id;
    frame_next.type_code = type_code;
    frame_next.v1_length = v1_length;
    frame_next.v3_length = v3_length;
    frame_next.v4_length = v4_length;
    frame_next.selector_byte = selector_byte;
    idx_pos = bpvc_pkg::pos_t'(byte_count);
    v4_pos = bpvc_pkg::pos_t'(v3_length) + bpvc_pkg::pos_t'(bpvc_pkg::V3_END);
    if (byte_count != bpvc_pkg::LEN_MAX) begin
      frame_next.size = byte_count + bpvc_pkg::len_t'(1);
      if (idx_pos < bpvc_pkg::pos_t'(2)) begin
        if (s1_byte != 8'd0) begin
          frame_next.proto_nonzero = 1'b1;
        end
      end else if (idx_pos == bpvc_pkg::pos_t'(2)) begin
        frame_next.version_id = s1_byte;
      end else if (idx_pos == bpvc_pkg::pos_t'(3)) begin
        frame_next.type_code = s1_byte;
      end else if (idx_pos == bpvc_pkg::pos_t'(bpvc_pkg::V1_OFFSET)) begin
        frame_next.v1_length = s1_byte;
      end else if (idx_pos == bpvc_pkg::pos_t'(bpvc_pkg::V3_OFFSET)) begin
        frame_next.v3_length = {s1_byte, v3_length[7:0]};
      end else if (idx_pos == bpvc_pkg::pos_t'(bpvc_pkg::V3_OFFSET + 1)) begin
        frame_next.v3_length = {v3_length[15:8], s1_byte};
      end else if (idx_pos >= bpvc_pkg::pos_t'(bpvc_pkg::V3_END)) begin
        if (idx_pos == v4_pos) begin
          frame_next.v4_length = {s1_byte, v4_length[7:0]};
        end else if (idx_pos == v4_pos + bpvc_pkg::pos_t'(1)) begin
          frame_next.v4_length = {v4_length[15:8], s1_byte};
        end else if (idx_pos == v4_pos + bpvc_pkg::pos_t'(2)) begin
          frame_next.selector_byte = s1_byte;
        end
      end
    end
  end

  bpvc_class u_class (
    .frame          (frame_next),
    .bridge_version (bridge_version),
    .bpdu_class     (class_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      proto_nonzero <= 1'b0;
      version_id <= '0;
      type_code <= '0;
      v1_length <= '0;
      v3_length <= '0;
      v4_length <= '0;
      selector_byte <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        byte_count <= '0;
        proto_nonzero <= 1'b0;
        version_id <= '0;
        type_code <= '0;
        v1_length <= '0;
        v3_length <= '0;
        v4_length <= '0;
        selector_byte <= '0;
      end else begin
        byte_count <= frame_next.size;
        proto_nonzero <= frame_next.proto_nonzero;
        version_id <= frame_next.version_id;
        type_code <= frame_next.type_code;
        v1_length <= frame_next.v1_length;
        v3_length <= frame_next.v3_length;
        v4_length <= frame_next.v4_length;
        selector_byte <= frame_next.selector_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_class <= class_next;
      out_length <= bpvc_pkg::FRAME_LEN_W'(frame_next.size);
    end
  end

  assign result.valid = out_valid;
  assign result.bpdu_class = out_class;
  assign result.frame_length = out_length;

endmodule

FILE: rtl/core/bpvc_class.sv
`timescale 1ns / 1ps

module bpvc_class (
  input  bpvc_pkg::frame_t frame,
  input  bpvc_pkg::bv_t    bridge_version,
  output bpvc_pkg::class_t bpdu_class
);

  logic rst_type;
  logic ver_ge3;
  logic ver_ge4;
  logic ver_eq2;
  logic ver_eq3;
  logic bv_le2;
  logic bv_ge3;
  logic bv_eq3;
  logic bv_gt3;
  logic sz_ge4;
  logic sz_ge35;
  logic sz_ge36;
  logic sz_ge38;
  logic sz_ge102;
  logic sz_ge106;
  logic v1_zero;
  logic v1_nonzero;
  logic v3_int;
  logic v3_ok;
  logic v3_bad;
  logic spt_wf;
  bpvc_pkg::pos_t size_pos;
  bpvc_pkg::pos_t spt_end;

  always_comb begin
    rst_type = (frame.type_code == bpvc_pkg::TYPE_RST);
    ver_ge3 = (frame.version_id >= 8'd3);
    ver_ge4 = (frame.version_id >= 8'd4);
    ver_eq2 = (frame.version_id == 8'd2);
    ver_eq3 = (frame.version_id == 8'd3);
    bv_le2 = (bridge_version <= bpvc_pkg::BV_RSTP);
    bv_ge3 = (bridge_version >= bpvc_pkg::BV_MSTP);
    bv_eq3 = (bridge_version == bpvc_pkg::BV_MSTP);
    bv_gt3 = (bridge_version > bpvc_pkg::BV_MSTP);

    size_pos = bpvc_pkg::pos_t'(frame.size);
    sz_ge4 = (size_pos >= bpvc_pkg::pos_t'(4));
    sz_ge35 = (size_pos >= bpvc_pkg::pos_t'(bpvc_pkg::V1_OFFSET));
    sz_ge36 = (size_pos >= bpvc_pkg::pos_t'(bpvc_pkg::V3_OFFSET));
    sz_ge38 = (size_pos >= bpvc_pkg::pos_t'(bpvc_pkg::V3_END));
    sz_ge102 = (size_pos >= bpvc_pkg::pos_t'(bpvc_pkg::SHORT_LIMIT));
    sz_ge106 = (size_pos >= bpvc_pkg::pos_t'(bpvc_pkg::SPT_LIMIT));

    v1_zero = sz_ge36 && (frame.v1_length == 8'd0);
    v1_nonzero = sz_ge36 && (frame.v1_length != 8'd0);

    // msti count must be whole and within limit
    v3_int = (frame.v3_length >= 16'(bpvc_pkg::CIST_V3_LEN)) &&
             (frame.v3_length[3:0] == 4'd0) &&
             (frame.v3_length <= 16'(bpvc_pkg::V3_MAX));
    v3_ok = sz_ge38 && v3_int;
    v3_bad = sz_ge38 && !v3_int;

    spt_end = bpvc_pkg::pos_t'(frame.v3_length) +
              bpvc_pkg::pos_t'(bpvc_pkg::V3_END + bpvc_pkg::SPT_TRAILER);
    spt_wf = (size_pos >= spt_end) &&
             (frame.v4_length >= 16'(bpvc_pkg::SPT_V4_MIN)) &&
             (frame.selector_byte == 8'd1);

    if (!sz_ge4 || frame.proto_nonzero) begin
      bpdu_class = bpvc_pkg::CLASS_UNKNOWN;
    end else if (frame.type_code == bpvc_pkg::TYPE_CONFIG && sz_ge35) begin
      bpdu_class = bpvc_pkg::CLASS_STP;
    end else if (frame.type_code == bpvc_pkg::TYPE_TCN) begin
      bpdu_class = bpvc_pkg::CLASS_TCN;
    end else if (ver_eq2 && rst_type && sz_ge36) begin
      bpdu_class = bpvc_pkg::CLASS_RST;
    end else if (ver_ge3 && rst_type && sz_ge36 && bv_le2) begin
      bpdu_class = bpvc_pkg::CLASS_RST;
    end else if (ver_ge3 && rst_type && bv_ge3 &&
                 ((sz_ge35 && !sz_ge102) || v1_nonzero || v3_bad)) begin
      bpdu_class = bpvc_pkg::CLASS_RST;
    end else if (((ver_ge3 && bv_eq3) || (ver_eq3 && bv_gt3)) && rst_type &&
                 sz_ge102 && v1_zero && v3_ok) begin
      bpdu_class = bpvc_pkg::CLASS_MST;
    end else if (ver_ge3 && rst_type && bv_gt3 && sz_ge102 && v1_zero && v3_ok &&
                 !spt_wf) begin
      bpdu_class = bpvc_pkg::CLASS_MST;
    end else if (ver_ge4 && rst_type && bv_ge3 && sz_ge106 && v1_zero && v3_ok &&
                 spt_wf) begin
      bpdu_class = bpvc_pkg::CLASS_SPT;
    end else begin
      bpdu_class = bpvc_pkg::CLASS_UNKNOWN;
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned SETTLE = 8;
  localparam int unsigned V1_POS = 35;
  localparam int unsigned V3_POS = 36;
  localparam int unsigned V4_BASE = 38;
  localparam int unsigned MIN_SIZE = 4;
  localparam int unsigned STP_SIZE = 35;
  localparam int unsigned V1_SIZE = 36;
  localparam int unsigned SHORT_SIZE = 102;
  localparam int unsigned SPT_SIZE = 106;
  localparam int unsigned V4_MIN = 55;
  localparam int unsigned CIST_LEN = 64;
  localparam int unsigned MSTI_LEN = 16;
  localparam int unsigned MSTI_MAX = 64;
  localparam int unsigned SPT_TAIL = 6;
  localparam int unsigned COUNT_MAX = (1 << bpvc_pkg::LENGTH_BITS) - 1;

  localparam logic [7:0] VER_STP = 8'd0;
  localparam logic [7:0] VER_RSTP = 8'd2;
  localparam logic [7:0] VER_MSTP = 8'd3;
  localparam logic [7:0] VER_SPT = 8'd4;
  localparam logic [7:0] SEL_SPT = 8'd1;

  localparam bpvc_pkg::bv_t BV_STP = 3'd0;
  localparam bpvc_pkg::bv_t BV_ONE = 3'd1;
  localparam bpvc_pkg::bv_t BV_SPT = 3'd4;
  localparam bpvc_pkg::bv_t BV_FIVE = 3'd5;
  localparam bpvc_pkg::bv_t BV_TOP = 3'd7;

  typedef struct {
    bpvc_pkg::class_t cls;
    logic [bpvc_pkg::FRAME_LEN_W-1:0] octets;
  } verdict_t;

  logic clk;
  logic rst;

  bpvc_cfg_if cfg_ch ();
  bpvc_octet_if octet_ch ();
  bpvc_result_if result_ch ();

  bpdu_validation_classifier dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .octet  (octet_ch),
    .result (result_ch)
  );

  verdict_t verdicts_due[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit sender_gaps = 1'b1;
  int unsigned hold_off_request = 0;

  // predictor state for the BPDU in flight
  bpvc_pkg::bv_t bridge_version = bpvc_pkg::BV_MSTP;
  int unsigned octets_seen = 0;
  bit pid_set = 1'b0;
  logic [7:0] ver_q = '0;
  logic [7:0] type_q = '0;
  logic [7:0] v1_q = '0;
  logic [15:0] v3_q = '0;
  logic [15:0] v4_q = '0;
  logic [7:0] sel_q = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic bpvc_pkg::class_t classify_bpdu(input int unsigned size);
    bit rst_kind, v1_zero, v1_set, integral, v3_fit, v3_misfit, spt_form;
    int unsigned ver, bv, v3, rest;
    ver = 32'(ver_q);
    bv = 32'(bridge_version);
    v3 = 32'(v3_q);
    rst_kind = (type_q == bpvc_pkg::TYPE_RST);
    v1_zero = size >= V1_SIZE && v1_q == 8'd0;
    v1_set = size >= V1_SIZE && v1_q != 8'd0;
    rest = v3 - CIST_LEN;
    integral = v3 >= CIST_LEN && rest % MSTI_LEN == 0 && rest / MSTI_LEN <= MSTI_MAX;
    v3_fit = size >= V4_BASE && integral;
    v3_misfit = size >= V4_BASE && !integral;
    spt_form = size >= V4_BASE + v3 + SPT_TAIL && 32'(v4_q) >= V4_MIN && sel_q == SEL_SPT;
    if (size < MIN_SIZE || pid_set) return bpvc_pkg::CLASS_UNKNOWN;
    if (type_q == bpvc_pkg::TYPE_CONFIG && size >= STP_SIZE) return bpvc_pkg::CLASS_STP;
    if (type_q == bpvc_pkg::TYPE_TCN) return bpvc_pkg::CLASS_TCN;
    if (ver == VER_RSTP && rst_kind && size >= V1_SIZE) return bpvc_pkg::CLASS_RST;
    if (ver >= VER_MSTP && rst_kind && size >= V1_SIZE && bv <= bpvc_pkg::BV_RSTP)
      return bpvc_pkg::CLASS_RST;
    if (ver >= VER_MSTP && rst_kind && bv >= bpvc_pkg::BV_MSTP &&
        ((size >= STP_SIZE && size < SHORT_SIZE) || v1_set || v3_misfit))
      return bpvc_pkg::CLASS_RST;
    if (((ver >= VER_MSTP && bv == bpvc_pkg::BV_MSTP) ||
         (ver == VER_MSTP && bv > bpvc_pkg::BV_MSTP)) &&
        rst_kind && size >= SHORT_SIZE && v1_zero && v3_fit)
      return bpvc_pkg::CLASS_MST;
    if (ver >= VER_MSTP && rst_kind && bv > bpvc_pkg::BV_MSTP && size >= SHORT_SIZE &&
        v1_zero && v3_fit && !spt_form)
      return bpvc_pkg::CLASS_MST;
    if (ver >= VER_SPT && rst_kind && bv >= bpvc_pkg::BV_MSTP && size >= SPT_SIZE &&
        v1_zero && v3_fit && spt_form)
      return bpvc_pkg::CLASS_SPT;
    return bpvc_pkg::CLASS_UNKNOWN;
  endfunction

  task automatic absorb_octet(input logic [7:0] b, input logic last);
    verdict_t v;
    int unsigned v4_at;
    v4_at = V4_BASE + 32'(v3_q);
    if (octets_seen < COUNT_MAX) begin
      if (octets_seen < 2) begin
        if (b != 8'd0) pid_set = 1'b1;
      end else if (octets_seen == 2) begin
        ver_q = b;
      end else if (octets_seen == 3) begin
        type_q = b;
      end else if (octets_seen == V1_POS) begin
        v1_q = b;
      end else if (octets_seen == V3_POS) begin
        v3_q[15:8] = b;
      end else if (octets_seen == V3_POS + 1) begin
        v3_q[7:0] = b;
      end else if (octets_seen >= V4_BASE) begin
        if (octets_seen == v4_at) v4_q[15:8] = b;
        else if (octets_seen == v4_at + 1) v4_q[7:0] = b;
        else if (octets_seen == v4_at + 2) sel_q = b;
      end
      octets_seen++;
    end
    if (last) begin
      v.cls = classify_bpdu(octets_seen);
      v.octets = octets_seen[bpvc_pkg::FRAME_LEN_W-1:0];
      verdicts_due.push_back(v);
      octets_seen = 0;
      pid_set = 1'b0;
      ver_q = '0;
      type_q = '0;
      v1_q = '0;
      v3_q = '0;
      v4_q = '0;
      sel_q = '0;
    end
  endtask

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result class %0d length %0d",
                                    result_ch.bpdu_class, result_ch.frame_length));
        end else begin
          want = verdicts_due.pop_front();
          if (result_ch.bpdu_class !== want.cls)
            report_mismatch($sformatf("class %0d, expected %0d (length %0d)",
                                      result_ch.bpdu_class, want.cls, want.octets));
          if (result_ch.frame_length !== want.octets)
            report_mismatch($sformatf("frame_length %0d, expected %0d",
                                      result_ch.frame_length, want.octets));
        end
      end
      if (octet_ch.valid && octet_ch.ready)
        absorb_octet(octet_ch.data_byte, octet_ch.last_byte);
    end
  end

  // result side: random stall patterns, plus long hold-offs on request
  initial begin : result_sink
    int unsigned left, mode, held;
    left = 0;
    mode = 0;
    held = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        held = hold_off_request;
        hold_off_request = 0;
      end
      if (held != 0) begin
        held--;
        result_ch.ready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 150);
        end
        left--;
        case (mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          2: result_ch.ready <= (left % 3 != 0);
          default: result_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bpdu_validation_classifier: mismatch");
    $finish;
  end

  task automatic send_octet(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        octet_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    octet_ch.valid <= 1'b1;
    octet_ch.data_byte <= b;
    octet_ch.last_byte <= last;
    do @(posedge clk); while (!octet_ch.ready);
  endtask

  task automatic send_bpdu(input int unsigned len, input logic [7:0] ver, input logic [7:0] typ,
                           input logic [7:0] v1, input logic [15:0] v3, input logic [15:0] v4,
                           input logic [7:0] sel, input logic [15:0] pid, input bit scramble);
    int unsigned i, hit, v4_at;
    logic [7:0] b;
    hit = scramble ? $urandom_range(0, len - 1) : len;
    v4_at = V4_BASE + 32'(v3);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0) b = pid[15:8];
      else if (i == 1) b = pid[7:0];
      else if (i == 2) b = ver;
      else if (i == 3) b = typ;
      else if (i == V1_POS) b = v1;
      else if (i == V3_POS) b = v3[15:8];
      else if (i == V3_POS + 1) b = v3[7:0];
      else if (i == v4_at) b = v4[15:8];
      else if (i == v4_at + 1) b = v4[7:0];
      else if (i == v4_at + 2) b = sel;
      if (i == hit) b = 8'($urandom_range(0, 255));
      send_octet(b, i == len - 1);
    end
  endtask

  task automatic drain(input int unsigned settle);
    octet_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_bridge_version(input bpvc_pkg::bv_t v);
    drain(SETTLE);
    cfg_ch.valid <= 1'b1;
    cfg_ch.bridge_protocol_version <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    bridge_version = v;
  endtask

  task automatic send_random_bpdu();
    int unsigned pick, len, n;
    logic [7:0] ver, typ, v1, sel;
    logic [15:0] v3, v4, pid;
    pick = $urandom_range(0, 99);
    ver = 8'($urandom_range(VER_MSTP, 5));
    if ($urandom_range(0, 7) == 0) ver = 8'($urandom_range(0, 255));
    typ = bpvc_pkg::TYPE_RST;
    v1 = 8'd0;
    pid = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(1, 65535)) : 16'd0;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MSTI_MAX + 1) : $urandom_range(0, 3);
    v3 = 16'(CIST_LEN + MSTI_LEN * n);
    if ($urandom_range(0, 5) == 0) v3 = v3 + 16'($urandom_range(1, MSTI_LEN - 1));
    if ($urandom_range(0, 9) == 0) v3 = 16'($urandom_range(0, CIST_LEN - 1));
    v4 = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(50, 60));
    sel = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : SEL_SPT;
    len = V4_BASE + 32'(v3) + $urandom_range(0, 8);
    if ($urandom_range(0, 4) == 0) len = $urandom_range(SHORT_SIZE - 3, SHORT_SIZE + 2);
    if (pick < 12) begin
      typ = bpvc_pkg::TYPE_CONFIG;
      ver = 8'($urandom_range(0, 255));
      len = $urandom_range(STP_SIZE - 2, STP_SIZE + 5);
    end else if (pick < 22) begin
      typ = bpvc_pkg::TYPE_TCN;
      ver = 8'($urandom_range(0, 255));
      len = $urandom_range(MIN_SIZE - 1, 8);
    end else if (pick < 40) begin
      if (pick < 30) ver = VER_RSTP;
      v1 = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
      len = $urandom_range(STP_SIZE - 1, 110);
    end else if (pick >= 90) begin
      ver = 8'($urandom_range(0, 255));
      typ = 8'($urandom_range(0, 255));
      v1 = 8'($urandom_range(0, 255));
      v3 = 16'($urandom_range(0, 65535));
      pid = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(0, 65535));
      len = $urandom_range(1, 120);
    end
    send_bpdu(len, ver, typ, v1, v3, v4, sel, pid, $urandom_range(0, 9) == 0);
  endtask

  task automatic test_short_and_legacy();
    send_bpdu(1, VER_STP, bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 0, 0);
    send_bpdu(2, VER_STP, bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 0, 0);
    send_bpdu(3, VER_STP, bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 0, 0);
    send_bpdu(MIN_SIZE, VER_STP, bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 0, 0);
    send_bpdu(MIN_SIZE, VER_STP, bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 16'h0001, 0);
    send_bpdu(STP_SIZE - 1, VER_STP, bpvc_pkg::TYPE_CONFIG, 0, 0, 0, 0, 0, 0);
    send_bpdu(STP_SIZE, VER_STP, bpvc_pkg::TYPE_CONFIG, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_rst_rules();
    send_bpdu(STP_SIZE, VER_RSTP, bpvc_pkg::TYPE_RST, 0, 0, 0, 0, 0, 0);
    send_bpdu(V1_SIZE, VER_RSTP, bpvc_pkg::TYPE_RST, 0, 0, 0, 0, 0, 0);
    send_bpdu(SHORT_SIZE - 1, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 0, 0, 0, 0);
    send_bpdu(SHORT_SIZE, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 0, 0, 0, 0);
    send_bpdu(SHORT_SIZE, VER_MSTP, bpvc_pkg::TYPE_RST, 8'd5, 16'(CIST_LEN), 0, 0, 0, 0);
    send_bpdu(SHORT_SIZE + 1, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN + 1), 0, 0, 0, 0);
  endtask

  task automatic test_spt_rules();
    int unsigned wf;
    wf = V4_BASE + CIST_LEN + SPT_TAIL;
    write_bridge_version(BV_SPT);
    send_bpdu(wf, VER_SPT, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 16'(V4_MIN), SEL_SPT, 0, 0);
    send_bpdu(wf, VER_SPT, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 16'(V4_MIN - 1), SEL_SPT,
              0, 0);
    send_bpdu(wf, VER_SPT, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 16'(V4_MIN), 8'd2, 0, 0);
    send_bpdu(wf - 1, VER_SPT, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 16'(V4_MIN), SEL_SPT,
              0, 0);
    send_bpdu(wf, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 16'hFFFF, SEL_SPT, 0, 0);
    // largest instance count, then one too many
    send_bpdu(SHORT_SIZE, 8'hFF, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN + MSTI_LEN * MSTI_MAX),
              16'(V4_MIN), SEL_SPT, 0, 0);
    send_bpdu(SHORT_SIZE, VER_SPT, bpvc_pkg::TYPE_RST, 0,
              16'(CIST_LEN + MSTI_LEN * (MSTI_MAX + 1)), 16'(V4_MIN), SEL_SPT, 0, 0);
  endtask

  task automatic test_register_extremes();
    write_bridge_version(BV_STP);
    send_bpdu(V1_SIZE, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 0, 0, 0, 0, 0);
    send_bpdu(SHORT_SIZE, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN), 0, 0, 0, 0);
    write_bridge_version(BV_TOP);
    send_bpdu(V4_BASE + CIST_LEN + SPT_TAIL, VER_SPT, bpvc_pkg::TYPE_RST, 0, 16'(CIST_LEN),
              16'(V4_MIN), SEL_SPT, 0, 0);
    write_bridge_version(BV_ONE);
    send_bpdu(V1_SIZE, VER_MSTP, bpvc_pkg::TYPE_RST, 0, 0, 0, 0, 0, 0);
    write_bridge_version(bpvc_pkg::BV_RSTP);
    send_bpdu(V1_SIZE, VER_SPT, bpvc_pkg::TYPE_RST, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    int unsigned k;
    drain(SETTLE);
    sender_gaps = 1'b0;
    hold_off_request = 300;
    for (k = 0; k < 40; k++)
      send_bpdu(MIN_SIZE, 8'($urandom_range(0, 255)), bpvc_pkg::TYPE_TCN, 0, 0, 0, 0, 0, 0);
    drain(SETTLE);
    sender_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    bpvc_pkg::bv_t plan [7];
    int unsigned p;
    plan = '{bpvc_pkg::BV_MSTP, BV_STP, BV_SPT, bpvc_pkg::BV_RSTP, BV_ONE, BV_FIVE, BV_TOP};
    for (p = 0; p < 7; p++) begin
      write_bridge_version(plan[p]);
      sender_gaps = ($urandom_range(0, 3) != 0);
      send_random_bpdu();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.bridge_protocol_version <= bpvc_pkg::BV_MSTP;
    octet_ch.valid <= 1'b0;
    octet_ch.data_byte <= 8'd0;
    octet_ch.last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_short_and_legacy();
    test_rst_rules();
    test_spt_rules();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();
    drain(SETTLE * 4);
    if (mismatches == 0) begin
      $display("bpdu_validation_classifier: match");
    end else begin
      $display("bpdu_validation_classifier: mismatch");
    end
    $finish;
  end

endmodule
